[hw/rtl/lobm_pkg.sv]
// shared types and constants of the limit order book matcher
// used by lobm_ctrl, lobm_dp and limit_order_book_matcher; depends on nothing
package lobm_pkg;

   localparam int ORDER_SLOTS_DEF = 64;
   localparam int PRICE_BITS_DEF  = 16;
   localparam int QTY_BITS_DEF    = 32;

   localparam int ID_W        = 32;
   localparam int PRICE_W     = 16;
   localparam int AMOUNT_W    = 32;
   localparam int REQ_DATA_W  = 80;
   localparam int REQ_USER_W  = 4;
   localparam int RSP_DATA_W  = 160;
   localparam int RSP_USER_W  = 3;

   typedef enum logic [1:0] {
      MODE_ADD    = 2'd0,
      MODE_CANCEL = 2'd1,
      MODE_MODIFY = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      KIND_TRADE     = 3'd0,
      KIND_ACCEPTED  = 3'd1,
      KIND_FOK_REJ   = 3'd2,
      KIND_BOOK_FULL = 3'd3,
      KIND_ZERO_QTY  = 3'd4,
      KIND_CANCELLED = 3'd5,
      KIND_UNKNOWN   = 3'd6
   } kind_type;

   typedef struct packed {
      logic     take_req;
      logic     scan_go;
      logic     scan_tgt;
      logic     kill_target;
      logic     alloc_id;
      logic     insert;
      logic     set_pend;
      kind_type pend_kind;
      logic     pend_new_id;
      logic     pend_trade;
      logic     emit;
      logic     emit_last;
      logic     trade_bid;
      logic     trade_ask;
   } cmd_type;

   typedef struct packed {
      logic     scan_done;
      logic [1:0] mode;
      logic     found;
      logic     free_found;
      logic     qty_zero;
      logic     fok_eff;
      logic     fok_cross;
      logic     book_cross;
      logic     out_busy;
   } status_type;

endpackage

[hw/rtl/limit_order_book_matcher.sv]
// Price-time priority limit order book. Each request word (add, cancel, modify) starts
// one scan of all order slots, one slot a cycle through the slot memory's single read
// port; that scan finds the target order, the first free slot and the best bid and ask.
// A cancel, an unknown id or a rejected order loads its one result word once that scan
// is done. An admitted order needs one more scan of the book before its acceptance word
// is loaded, and every trade after it costs an update of the bid, an update of the ask
// and a fresh scan. The next request is taken only once the last word of a request is
// loaded and the sequencer is back in idle, so requests never overlap. The output holds
// one word; while it waits on rsp_tready the next word of the request waits as well.
// Results leave one word per handshake, the last one of a request with tlast set.
// Depends on lobm_pkg, lobm_ctrl and lobm_dp.
module limit_order_book_matcher #(
   parameter int ORDER_SLOTS = lobm_pkg::ORDER_SLOTS_DEF,
   parameter int PRICE_BITS  = lobm_pkg::PRICE_BITS_DEF,
   parameter int QTY_BITS    = lobm_pkg::QTY_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // target_id[31:0], limit_price[47:32], amount[79:48]
   input  logic [lobm_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode[1:0], is_sell[2], fill_or_kill[3]
   input  logic [lobm_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // new_id[31:0], buyer_id[63:32], buyer_price[79:64], seller_id[111:80],
   // seller_price[127:112], traded[159:128]
   output logic [lobm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // kind[2:0]
   output logic [lobm_pkg::RSP_USER_W-1:0] rsp_tuser,
   output logic                            rsp_tlast
);
   import lobm_pkg::*;

   cmd_type    cmd;
   status_type sts;

   lobm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lobm_dp #(
      .ORDER_SLOTS (ORDER_SLOTS),
      .PRICE_BITS  (PRICE_BITS),
      .QTY_BITS    (QTY_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

[hw/rtl/lobm_ctrl.sv]
// sequencer of the limit order book matcher: scans, decisions, trades, result words
// depends on lobm_pkg; drives lobm_dp through cmd_type and reads status_type
module lobm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  lobm_pkg::status_type sts,
   output lobm_pkg::cmd_type    cmd
);
   import lobm_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE      = 8'b0000_0001,
      ST_SCAN_REQ  = 8'b0000_0010,
      ST_DECIDE    = 8'b0000_0100,
      ST_SCAN_BOOK = 8'b0000_1000,
      ST_CHECK     = 8'b0001_0000,
      ST_EMIT      = 8'b0010_0000,
      ST_TRADE_B   = 8'b0100_0000,
      ST_TRADE_A   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      last_ff, last_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      last_in  = last_ff;
      cmd      = '0;
      cmd.pend_kind = KIND_UNKNOWN;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.take_req = 1'b1;
               cmd.scan_go  = 1'b1;
               cmd.scan_tgt = 1'b1;
               state_in     = ST_SCAN_REQ;
            end
         end
         ST_SCAN_REQ: begin
            if (sts.scan_done) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.set_pend = 1'b1;
            last_in      = 1'b1;
            state_in     = ST_EMIT;
            if (sts.mode != MODE_ADD && sts.mode != MODE_CANCEL &&
                sts.mode != MODE_MODIFY) begin
               cmd.pend_kind = KIND_UNKNOWN;
            end else if (sts.mode != MODE_ADD && !sts.found) begin
               cmd.pend_kind = KIND_UNKNOWN;
            end else if (sts.mode == MODE_CANCEL) begin
               cmd.kill_target = 1'b1;
               cmd.pend_kind   = KIND_CANCELLED;
            end else begin
               cmd.kill_target = (sts.mode == MODE_MODIFY);
               if (sts.qty_zero) begin
                  cmd.pend_kind = KIND_ZERO_QTY;
               end else if (!sts.free_found) begin
                  cmd.pend_kind = KIND_BOOK_FULL;
               end else if (sts.fok_eff && !sts.fok_cross) begin
                  cmd.alloc_id  = 1'b1;
                  cmd.pend_kind = KIND_FOK_REJ;
               end else begin
                  cmd.alloc_id    = 1'b1;
                  cmd.insert      = 1'b1;
                  cmd.pend_kind   = KIND_ACCEPTED;
                  cmd.pend_new_id = 1'b1;
                  cmd.scan_go     = 1'b1;
                  state_in        = ST_SCAN_BOOK;
               end
            end
         end
         ST_SCAN_BOOK: begin
            if (sts.scan_done) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // a crossing book means another trade follows the pending word
            last_in  = !sts.book_cross;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!sts.out_busy) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = last_ff;
               state_in      = last_ff ? ST_IDLE : ST_TRADE_B;
            end
         end
         ST_TRADE_B: begin
            cmd.pend_trade = 1'b1;
            cmd.trade_bid  = 1'b1;
            state_in       = ST_TRADE_A;
         end
         ST_TRADE_A: begin
            cmd.trade_ask = 1'b1;
            cmd.scan_go   = 1'b1;
            state_in      = ST_SCAN_BOOK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

endmodule

[hw/rtl/lobm_dp.sv]
// datapath of the limit order book matcher: slot memories, scan unit, id counter,
// pending and output result words; depends on lobm_pkg, commanded by lobm_ctrl
module lobm_dp #(
   parameter int ORDER_SLOTS = lobm_pkg::ORDER_SLOTS_DEF,
   parameter int PRICE_BITS  = lobm_pkg::PRICE_BITS_DEF,
   parameter int QTY_BITS    = lobm_pkg::QTY_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [lobm_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [lobm_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lobm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [lobm_pkg::RSP_USER_W-1:0]     rsp_tuser,
   output logic                                rsp_tlast,
   input  lobm_pkg::cmd_type                   cmd,
   output lobm_pkg::status_type                sts
);
   import lobm_pkg::*;

   localparam int SLOT_W = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ORDER_SLOTS - 1);

   typedef struct packed {
      logic [ID_W-1:0]       id;
      logic [PRICE_BITS-1:0] price;
      logic                  sell;
      logic                  fok;
   } meta_type;

   // slot storage
   meta_type              meta_mem [ORDER_SLOTS];
   logic [QTY_BITS-1:0]   rem_mem  [ORDER_SLOTS];
   logic [ORDER_SLOTS-1:0] valid_ff, valid_in;
   meta_type              rd_meta_ff;
   logic [QTY_BITS-1:0]   rd_rem_ff;
   logic [ID_W-1:0]       next_id_ff;
   logic                  rsp_tvalid_ff;

   // request
   logic [1:0]            mode_ff;
   logic [ID_W-1:0]       target_ff;
   logic [PRICE_BITS-1:0] price_ff;
   logic [QTY_BITS-1:0]   qty_ff;
   logic                  sell_ff, fok_ff;
   logic [PRICE_BITS+PRICE_W-1:0]  price_ext;
   logic [QTY_BITS+AMOUNT_W-1:0]   qty_ext;

   assign price_ext = {{PRICE_BITS{1'b0}}, req_tdata[47:32]};
   assign qty_ext   = {{QTY_BITS{1'b0}}, req_tdata[79:48]};

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         mode_ff   <= req_tuser[1:0];
         sell_ff   <= req_tuser[2];
         fok_ff    <= req_tuser[3];
         target_ff <= req_tdata[31:0];
         price_ff  <= price_ext[PRICE_BITS-1:0];
         qty_ff    <= qty_ext[QTY_BITS-1:0];
      end
   end

   // scan control: issue address, registered read, evaluate one slot a cycle
   logic              scan_ff, ev_ff, done_ff, tgt_ff;
   logic [SLOT_W-1:0] idx_ff, ev_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= 1'b0;
         ev_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         ev_ff   <= scan_ff;
         done_ff <= ev_ff && (ev_idx_ff == LAST_SLOT);
         if (cmd.scan_go) begin
            scan_ff <= 1'b1;
         end else if (scan_ff && idx_ff == LAST_SLOT) begin
            scan_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ev_idx_ff <= idx_ff;
      if (cmd.scan_go) begin
         idx_ff <= '0;
         tgt_ff <= cmd.scan_tgt;
      end else if (scan_ff) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   // accumulators of one scan
   logic                  found_ff, free_found_ff, bid_have_ff, ask_have_ff;
   logic [SLOT_W-1:0]     match_idx_ff, free_idx_ff, bid_idx_ff, ask_idx_ff;
   logic                  match_fok_ff;
   logic [PRICE_BITS-1:0] bid_p_ff, ask_p_ff;
   logic [ID_W-1:0]       bid_id_ff, ask_id_ff;
   logic [QTY_BITS-1:0]   bid_rem_ff, ask_rem_ff;
   logic                  hit, live, take_bid, take_ask;

   always_comb begin
      // only cancel and modify look for a target id
      hit  = tgt_ff && (mode_ff == MODE_CANCEL || mode_ff == MODE_MODIFY) &&
             valid_ff[ev_idx_ff] && !found_ff && (rd_meta_ff.id == target_ff);
      live = valid_ff[ev_idx_ff] && !hit;
      take_bid = live && !rd_meta_ff.sell &&
                 (!bid_have_ff || rd_meta_ff.price > bid_p_ff ||
                  (rd_meta_ff.price == bid_p_ff && rd_meta_ff.id < bid_id_ff));
      take_ask = live && rd_meta_ff.sell &&
                 (!ask_have_ff || rd_meta_ff.price < ask_p_ff ||
                  (rd_meta_ff.price == ask_p_ff && rd_meta_ff.id < ask_id_ff));
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_go) begin
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         bid_have_ff   <= 1'b0;
         ask_have_ff   <= 1'b0;
      end else if (ev_ff) begin
         if (hit) begin
            found_ff     <= 1'b1;
            match_idx_ff <= ev_idx_ff;
            match_fok_ff <= rd_meta_ff.fok;
         end
         // the slot being cancelled counts as free
         if (!live && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= ev_idx_ff;
         end
         if (take_bid) begin
            bid_have_ff <= 1'b1;
            bid_idx_ff  <= ev_idx_ff;
            bid_p_ff    <= rd_meta_ff.price;
            bid_id_ff   <= rd_meta_ff.id;
            bid_rem_ff  <= rd_rem_ff;
         end
         if (take_ask) begin
            ask_have_ff <= 1'b1;
            ask_idx_ff  <= ev_idx_ff;
            ask_p_ff    <= rd_meta_ff.price;
            ask_id_ff   <= rd_meta_ff.id;
            ask_rem_ff  <= rd_rem_ff;
         end
      end
   end

   // trade quantity and remainders
   logic [QTY_BITS-1:0] trade_q, bid_left, ask_left;
   assign trade_q  = (bid_rem_ff < ask_rem_ff) ? bid_rem_ff : ask_rem_ff;
   assign bid_left = bid_rem_ff - trade_q;
   assign ask_left = ask_rem_ff - trade_q;

   // memory ports
   logic                rem_we;
   logic [SLOT_W-1:0]   rem_wa;
   logic [QTY_BITS-1:0] rem_wd;
   meta_type            meta_wd;

   always_comb begin
      rem_we = cmd.insert || cmd.trade_bid || cmd.trade_ask;
      rem_wa = free_idx_ff;
      rem_wd = qty_ff;
      if (cmd.trade_bid) begin
         rem_wa = bid_idx_ff;
         rem_wd = bid_left;
      end else if (cmd.trade_ask) begin
         rem_wa = ask_idx_ff;
         rem_wd = ask_left;
      end
      meta_wd.id    = next_id_ff;
      meta_wd.price = price_ff;
      meta_wd.sell  = sell_ff;
      meta_wd.fok   = sts.fok_eff;
   end

   always_ff @(posedge clock) begin
      if (cmd.insert) meta_mem[free_idx_ff] <= meta_wd;
      if (rem_we) rem_mem[rem_wa] <= rem_wd;
      rd_meta_ff <= meta_mem[idx_ff];
      rd_rem_ff  <= rem_mem[idx_ff];
   end

   // a modify may free and refill the same slot in the same cycle
   always_comb begin
      valid_in = valid_ff;
      if (cmd.kill_target) valid_in[match_idx_ff] = 1'b0;
      if (cmd.insert) valid_in[free_idx_ff] = 1'b1;
      if (cmd.trade_bid && bid_left == '0) valid_in[bid_idx_ff] = 1'b0;
      if (cmd.trade_ask && ask_left == '0) valid_in[ask_idx_ff] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // id counter
   always_ff @(posedge clock) begin
      if (reset) begin
         next_id_ff <= '0;
      end else if (cmd.alloc_id) begin
         next_id_ff <= next_id_ff + 1'b1;
      end
   end

   // status
   always_comb begin
      sts.scan_done  = done_ff;
      sts.mode       = mode_ff;
      sts.found      = found_ff;
      sts.free_found = free_found_ff;
      sts.qty_zero   = (qty_ff == '0);
      sts.fok_eff    = (mode_ff == MODE_ADD) ? fok_ff : match_fok_ff;
      sts.fok_cross  = sell_ff ? (bid_have_ff && price_ff <= bid_p_ff)
                               : (ask_have_ff && price_ff >= ask_p_ff);
      sts.book_cross = bid_have_ff && ask_have_ff && (bid_p_ff >= ask_p_ff);
      sts.out_busy   = rsp_tvalid_ff;
   end

   // pending and output words
   kind_type              pend_kind_ff;
   logic [ID_W-1:0]       pend_new_ff, pend_bid_ff, pend_ask_ff;
   logic [PRICE_BITS-1:0] pend_bp_ff, pend_ap_ff;
   logic [QTY_BITS-1:0]   pend_q_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   kind_type              rsp_kind_ff;
   logic                  rsp_last_ff;

   always_ff @(posedge clock) begin
      if (cmd.set_pend) begin
         pend_kind_ff <= cmd.pend_kind;
         pend_new_ff  <= cmd.pend_new_id ? next_id_ff : '0;
         pend_bid_ff  <= '0;
         pend_ask_ff  <= '0;
         pend_bp_ff   <= '0;
         pend_ap_ff   <= '0;
         pend_q_ff    <= '0;
      end else if (cmd.pend_trade) begin
         pend_kind_ff <= KIND_TRADE;
         pend_new_ff  <= '0;
         pend_bid_ff  <= bid_id_ff;
         pend_bp_ff   <= bid_p_ff;
         pend_ask_ff  <= ask_id_ff;
         pend_ap_ff   <= ask_p_ff;
         pend_q_ff    <= trade_q;
      end
   end

   logic [PRICE_BITS+PRICE_W-1:0] bp_ext, ap_ext;
   logic [QTY_BITS+AMOUNT_W-1:0]  q_ext;
   assign bp_ext = {{PRICE_W{1'b0}}, pend_bp_ff};
   assign ap_ext = {{PRICE_W{1'b0}}, pend_ap_ff};
   assign q_ext  = {{AMOUNT_W{1'b0}}, pend_q_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_kind_ff <= pend_kind_ff;
         rsp_last_ff <= cmd.emit_last;
         rsp_data_ff <= {q_ext[AMOUNT_W-1:0], ap_ext[PRICE_W-1:0], pend_ask_ff,
                         bp_ext[PRICE_W-1:0], pend_bid_ff, pend_new_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
